// File: src/edd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance package
// Shared types and constants for the edit distance block.
// ----------------------------------------------------------------------------
package edd_pkg;

	localparam int MAX_LEN = 32;
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int DIM     = MAX_LEN + 1;
	localparam int CELLS   = DIM * DIM;
	localparam int CELL_W  = $clog2(CELLS);
	localparam int SCR_D   = 2 * MAX_LEN;
	localparam int SCR_W   = $clog2(SCR_D);
	localparam int CNT_W   = $clog2(SCR_D + 1);

	localparam logic [1:0] OP_SRC    = 2'd0;
	localparam logic [1:0] OP_TGT    = 2'd1;
	localparam logic [1:0] OP_RUN    = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] ACT_KEEP   = 3'd0;
	localparam logic [2:0] ACT_SUB    = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_ADD    = 3'd3;
	localparam logic [2:0] ACT_EMPTY  = 3'd4;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] character;
	} in_beat_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] from_char;
		logic [7:0] to_char;
		logic [5:0] total_distance;
		logic       overflow;
		logic       last;
	} out_beat_t;

	// One cell of the matrix: cost and the chosen move.
	typedef struct packed {
		logic [5:0] cost;
		logic [1:0] act;
	} cell_t;

endpackage
`default_nettype wire

// File: src/edit_distance_diff.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance with edit script
// Loads two strings, fills the cost matrix in a memory, traces back and
// emits the script in forward order.
// ----------------------------------------------------------------------------
// Appends give no result. A run fills the border, then handles each inner cell
// by reading the up, left and diagonal cells from the one-port-read matrix
// memory and then writing the cell, traces back with a read and a store per
// step, and emits each step with a script memory read and then the output.
// An empty run gives its single result through S_EMPTY and the output register.
// busy is high for the whole run; the receiver cannot stall. Reset clears
// lengths, the overflow flag and the sequencer; memories are not cleared.
module edit_distance_diff (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire edd_pkg::in_beat_t in_beat,
	output logic                   strobe,
	output edd_pkg::out_beat_t     out_beat
);

	typedef enum logic [3:0] {
		S_IDLE, S_BORDER, S_RD_UP, S_RD_LF, S_RD_DG, S_CALC,
		S_TB_RD, S_TB_ST, S_EMIT_RD, S_EMIT, S_EMPTY
	} state_t;

	state_t state_q;

	logic [7:0] src_mem [edd_pkg::MAX_LEN];
	logic [7:0] tgt_mem [edd_pkg::MAX_LEN];
	edd_pkg::cell_t mat_mem [edd_pkg::CELLS];
	logic [17:0] scr_mem [edd_pkg::SCR_D];

	logic [edd_pkg::LEN_W-1:0] src_len_q, tgt_len_q, i_q, j_q;
	logic overflow_q;
	logic [edd_pkg::CNT_W-1:0] cnt_q, k_q;
	logic [5:0] dist_q, up_q, lf_q;
	logic [7:0] sc_q, tc_q;
	edd_pkg::cell_t rd_q;
	logic [17:0] scr_rd_q;

	logic [edd_pkg::CELL_W-1:0] rd_addr, wr_addr;
	edd_pkg::cell_t wr_data;
	logic wr_en;
	logic [edd_pkg::IDX_W-1:0] si, ti;

	function automatic logic [edd_pkg::CELL_W-1:0] addr_of(
		input logic [edd_pkg::LEN_W-1:0] i, input logic [edd_pkg::LEN_W-1:0] j);
		addr_of = edd_pkg::CELL_W'(i * edd_pkg::DIM + j);
	endfunction

	assign busy = (state_q != S_IDLE);
	assign si = edd_pkg::IDX_W'(i_q - 1'b1);
	assign ti = edd_pkg::IDX_W'(j_q - 1'b1);

	// Read address for the matrix memory.
	always_comb begin
		case (state_q)
			S_RD_UP: rd_addr = addr_of(i_q - 1'b1, j_q);
			S_RD_LF: rd_addr = addr_of(i_q, j_q - 1'b1);
			S_RD_DG: rd_addr = addr_of(i_q - 1'b1, j_q - 1'b1);
			default: rd_addr = addr_of(i_q, j_q);
		endcase
	end

	// Cell computation; for the border the move is fixed.
	always_comb begin
		wr_addr = addr_of(i_q, j_q);
		wr_en   = 1'b0;
		wr_data = '0;
		if (state_q == S_BORDER) begin
			wr_en = 1'b1;
			if (j_q == '0) begin
				wr_data = {6'(i_q), edd_pkg::ACT_REMOVE[1:0]};
			end else begin
				wr_data = {6'(j_q), edd_pkg::ACT_ADD[1:0]};
			end
		end else if (state_q == S_CALC) begin
			wr_en = 1'b1;
			if (sc_q == tc_q) begin
				wr_data = {rd_q.cost, edd_pkg::ACT_KEEP[1:0]};
			end else if (rd_q.cost < up_q && rd_q.cost < lf_q) begin
				wr_data = {6'(rd_q.cost + 1'b1), edd_pkg::ACT_SUB[1:0]};
			end else if (lf_q < up_q) begin
				wr_data = {6'(lf_q + 1'b1), edd_pkg::ACT_ADD[1:0]};
			end else begin
				wr_data = {6'(up_q + 1'b1), edd_pkg::ACT_REMOVE[1:0]};
			end
		end
	end

	// Memories.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mat_mem[wr_addr] <= wr_data;
		end
		rd_q <= mat_mem[rd_addr];
		scr_rd_q <= scr_mem[edd_pkg::SCR_W'(cnt_q - k_q - 1'b1)];
		sc_q <= src_mem[si];
		tc_q <= tgt_mem[ti];
		if (state_q == S_IDLE && start && in_beat.operation == edd_pkg::OP_SRC
		    && src_len_q < edd_pkg::LEN_W'(edd_pkg::MAX_LEN)) begin
			src_mem[edd_pkg::IDX_W'(src_len_q)] <= in_beat.character;
		end
		if (state_q == S_IDLE && start && in_beat.operation == edd_pkg::OP_TGT
		    && tgt_len_q < edd_pkg::LEN_W'(edd_pkg::MAX_LEN)) begin
			tgt_mem[edd_pkg::IDX_W'(tgt_len_q)] <= in_beat.character;
		end
		if (state_q == S_TB_ST) begin
			unique case (rd_q.act)
				edd_pkg::ACT_KEEP[1:0]:   scr_mem[edd_pkg::SCR_W'(cnt_q)] <=
					{rd_q.act, sc_q, 8'd0};
				edd_pkg::ACT_SUB[1:0]:    scr_mem[edd_pkg::SCR_W'(cnt_q)] <=
					{rd_q.act, sc_q, tc_q};
				edd_pkg::ACT_REMOVE[1:0]: scr_mem[edd_pkg::SCR_W'(cnt_q)] <=
					{rd_q.act, sc_q, 8'd0};
				default:                  scr_mem[edd_pkg::SCR_W'(cnt_q)] <=
					{rd_q.act, 8'd0, tc_q};
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			src_len_q  <= '0;
			tgt_len_q  <= '0;
			overflow_q <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			cnt_q      <= '0;
			k_q        <= '0;
			dist_q     <= '0;
			up_q       <= '0;
			lf_q       <= '0;
			strobe     <= 1'b0;
			out_beat   <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						case (in_beat.operation)
							edd_pkg::OP_SRC: begin
								if (src_len_q < edd_pkg::LEN_W'(edd_pkg::MAX_LEN)) begin
									src_len_q <= src_len_q + 1'b1;
								end else begin
									overflow_q <= 1'b1;
								end
							end
							edd_pkg::OP_TGT: begin
								if (tgt_len_q < edd_pkg::LEN_W'(edd_pkg::MAX_LEN)) begin
									tgt_len_q <= tgt_len_q + 1'b1;
								end else begin
									overflow_q <= 1'b1;
								end
							end
							edd_pkg::OP_RUN: begin
								i_q   <= '0;
								j_q   <= '0;
								cnt_q <= '0;
								k_q   <= '0;
								if (src_len_q == '0 && tgt_len_q == '0) begin
									state_q <= S_EMPTY;
								end else begin
									state_q <= S_BORDER;
								end
							end
							default: ;
						endcase
					end
				end
				S_EMPTY: begin
					strobe   <= 1'b1;
					out_beat <= {edd_pkg::ACT_EMPTY, 8'd0, 8'd0, 6'd0, overflow_q, 1'b1};
					src_len_q  <= '0;
					tgt_len_q  <= '0;
					overflow_q <= 1'b0;
					state_q  <= S_IDLE;
				end
				// Column zero first, then row zero.
				S_BORDER: begin
					if (j_q == '0 && i_q != src_len_q) begin
						i_q <= i_q + 1'b1;
					end else if (j_q == '0) begin
						i_q <= '0;
						j_q <= edd_pkg::LEN_W'(1);
						if (tgt_len_q == '0) begin
							i_q <= src_len_q;
							j_q <= '0;
							state_q <= S_TB_RD;
						end
					end else if (j_q != tgt_len_q) begin
						j_q <= j_q + 1'b1;
					end else begin
						j_q <= edd_pkg::LEN_W'(1);
						i_q <= edd_pkg::LEN_W'(1);
						if (src_len_q == '0) begin
							i_q <= '0;
							j_q <= tgt_len_q;
							state_q <= S_TB_RD;
						end else begin
							state_q <= S_RD_UP;
						end
					end
				end
				S_RD_UP: state_q <= S_RD_LF;
				S_RD_LF: begin
					up_q    <= rd_q.cost;
					state_q <= S_RD_DG;
				end
				S_RD_DG: begin
					lf_q    <= rd_q.cost;
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (i_q != src_len_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_RD_UP;
					end else if (j_q != tgt_len_q) begin
						i_q     <= edd_pkg::LEN_W'(1);
						j_q     <= j_q + 1'b1;
						state_q <= S_RD_UP;
					end else begin
						dist_q  <= wr_data.cost;
						state_q <= S_TB_RD;
					end
				end
				// With one string empty the distance is the other length.
				S_TB_RD: begin
					if (i_q == '0 && j_q == '0) begin
						if (tgt_len_q == '0 || src_len_q == '0) begin
							dist_q <= 6'(src_len_q + tgt_len_q);
						end
						state_q <= S_EMIT_RD;
					end else begin
						state_q <= S_TB_ST;
					end
				end
				S_TB_ST: begin
					cnt_q <= cnt_q + 1'b1;
					unique case (rd_q.act)
						edd_pkg::ACT_KEEP[1:0], edd_pkg::ACT_SUB[1:0]: begin
							i_q <= i_q - 1'b1;
							j_q <= j_q - 1'b1;
						end
						edd_pkg::ACT_REMOVE[1:0]: i_q <= i_q - 1'b1;
						default: j_q <= j_q - 1'b1;
					endcase
					state_q <= S_TB_RD;
				end
				S_EMIT_RD: state_q <= S_EMIT;
				S_EMIT: begin
					strobe   <= 1'b1;
					out_beat <= {1'b0, scr_rd_q[17:16], scr_rd_q[15:8], scr_rd_q[7:0],
						dist_q, overflow_q, (k_q + 1'b1 == cnt_q)};
					k_q <= k_q + 1'b1;
					if (k_q + 1'b1 == cnt_q) begin
						src_len_q  <= '0;
						tgt_len_q  <= '0;
						overflow_q <= 1'b0;
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_EMIT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
